/* rtl/smpq_pkg.sv */
package smpq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned PRIO_BITS   = 16;
  localparam int unsigned HANDLE_BITS = 8;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [PRIO_BITS-1:0]   prio;
  } entry_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic ins;  // insert is committed this cycle
    logic pop;  // pop is committed this cycle
    logic occ;  // cell currently holds a live entry
  } cell_ctrl_t;

endpackage

/* rtl/smpq_in_if.sv */
interface smpq_in_if import smpq_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [HANDLE_BITS-1:0] item_handle;
  logic [PRIO_BITS-1:0]   priority_req;

  modport source (output valid, opcode, item_handle, priority_req, input ready);
  modport sink   (input valid, opcode, item_handle, priority_req, output ready);
endinterface

/* rtl/smpq_out_if.sv */
interface smpq_out_if import smpq_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [PRIO_BITS-1:0]   out_priority;
  logic                   out_valid;
  logic [1:0]             status;
  logic                   queue_empty;
  logic [CNT_W-1:0]       occupancy;

  modport source (output valid, out_handle, out_priority, out_valid, status, queue_empty,
                  occupancy, input ready);
  modport sink   (input valid, out_handle, out_priority, out_valid, status, queue_empty,
                  occupancy, output ready);
endinterface

/* rtl/smpq_cell.sv */
module smpq_cell import smpq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     left_i,
  input  logic       left_take_i,
  input  entry_t     right_i,
  output logic       take_o,
  output entry_t     entry_o
);

  entry_t entry_q;

  // strictly greater keeps equal priorities in arrival order
  assign take_o  = !ctrl_i.occ || (entry_q.prio > new_i.prio);
  assign entry_o = entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      entry_q <= right_i;
    end else if (ctrl_i.ins && take_o) begin
      entry_q <= left_take_i ? left_i : new_i;
    end
  end

endmodule

/* rtl/stable_min_priority_queue.sv */
// Sorted min-priority queue built as a chain of DEPTH entry cells.
// The result is registered and presented in the cycle after the input transfer.
// Throughput: one item per cycle while results are taken; every cell compares
// and shifts in the same cycle, and a single output register holds the result.
// Reset clears the entry count and the result valid flag; cell contents and
// result data are not reset.
module stable_min_priority_queue import smpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpq_in_if.sink     in_i,
  smpq_out_if.source  out_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept, full, empty, ins_en, pop_en;
  opcode_e          op;
  entry_t           new_entry;
  entry_t           cell_entry [DEPTH];
  logic             cell_take  [DEPTH];

  logic             res_vld_q;
  entry_t           res_entry_q, res_entry_d;
  logic             res_hit_q, res_hit_d;
  status_e          res_status_q, res_status_d;

  assign in_i.ready = !res_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign op         = opcode_e'(in_i.opcode);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign ins_en     = accept && (op == OP_INSERT) && !full;
  assign pop_en     = accept && (op == OP_POP) && !empty;

  assign new_entry.handle = in_i.item_handle;
  assign new_entry.prio   = in_i.priority_req;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     left, right;
    logic       left_take;

    assign ctrl.ins = ins_en;
    assign ctrl.pop = pop_en;
    assign ctrl.occ = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left      = '0;
      assign left_take = 1'b0;
    end else begin : g_body
      assign left      = cell_entry[i-1];
      assign left_take = cell_take[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = cell_entry[i+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .left_i      (left),
      .left_take_i (left_take),
      .right_i     (right),
      .take_o      (cell_take[i]),
      .entry_o     (cell_entry[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    res_entry_d  = '0;
    res_hit_d    = 1'b0;
    res_status_d = ST_OK;
    case (op)
      OP_INSERT: begin
        if (full) begin
          res_status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (empty) begin
          res_status_d = ST_EMPTY;
        end else begin
          res_entry_d = cell_entry[0];
          res_hit_d   = 1'b1;
          if (op == OP_POP) begin
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_entry_q  <= res_entry_d;
      res_hit_q    <= res_hit_d;
      res_status_q <= res_status_d;
    end
  end

  assign out_o.valid        = res_vld_q;
  assign out_o.out_handle   = res_entry_q.handle;
  assign out_o.out_priority = res_entry_q.prio;
  assign out_o.out_valid    = res_hit_q;
  assign out_o.status       = res_status_q;
  assign out_o.occupancy    = count_q;
  assign out_o.queue_empty  = (count_q == '0);

endmodule

/* rtl/smpq_checker.sv */
module smpq_checker import smpq_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_vld_i,
  input logic                   out_rdy_i,
  input logic [HANDLE_BITS-1:0] out_handle_i,
  input logic [PRIO_BITS-1:0]   out_priority_i,
  input logic                   out_valid_i,
  input logic [1:0]             status_i,
  input logic                   queue_empty_i,
  input logic [CNT_W-1:0]       occupancy_i
);

  // a stalled result must not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_rdy_i |=> out_vld_i && $stable(out_handle_i) && $stable(status_i)
      && $stable(out_priority_i) && $stable(occupancy_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && (status_i == ST_FULL) |-> (occupancy_i == CNT_W'(DEPTH)) && !out_valid_i)
    else $error("full status with free slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i |-> (queue_empty_i == (occupancy_i == '0)))
    else $error("empty flag disagrees with occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_valid_i |-> (out_handle_i == '0) && (out_priority_i == '0))
    else $error("payload nonzero without entry");

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_vld_i      (out_o.valid),
  .out_rdy_i      (out_o.ready),
  .out_handle_i   (out_o.out_handle),
  .out_priority_i (out_o.out_priority),
  .out_valid_i    (out_o.out_valid),
  .status_i       (out_o.status),
  .queue_empty_i  (out_o.queue_empty),
  .occupancy_i    (out_o.occupancy)
);
